// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and constants shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam logic [2:0] OUT_NONE    = 3'd0;
	localparam logic [2:0] OUT_ALL     = 3'd1;
	localparam logic [2:0] OUT_LINEAR  = 3'd2;
	localparam logic [2:0] OUT_TWO     = 3'd3;
	localparam logic [2:0] OUT_DOUBLE  = 3'd4;
	localparam logic [2:0] OUT_COMPLEX = 3'd5;
	localparam logic [2:0] OUT_HIGH    = 3'd6;

	localparam int DISC_W = 67;   // b*b + 4*|a*c|
	localparam int RAD_W  = 68;   // radicand, even width
	localparam int ROOT_W = 34;
	localparam int REM_W  = 36;
	localparam int SQ_STEPS = RAD_W / 2;
	localparam int DIV_W  = 67;   // dividend / shifted divisor width
	localparam int QUO_W  = 33;   // quotient bits below the overflow check

	typedef struct packed {
		logic signed [31:0] coef_constant;
		logic signed [31:0] coef_linear;
		logic signed [31:0] coef_square;
		logic               higher_terms_present;
	} eq_t;

	typedef struct packed {
		logic [2:0]         outcome;
		logic signed [31:0] root_low;
		logic signed [31:0] root_high;
		logic               saturated;
	} sol_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} meta_t;

	typedef struct packed {
		logic              valid;
		meta_t             meta;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] dsh;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} lane_t;

	typedef struct packed {
		logic             valid;
		logic [2:0]       kind;
		lane_t [1:0]      lane;
	} dv_t;

endpackage

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit-pair step of the restoring integer square root.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell import qrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  sq_t  d,
	output sq_t  q
);

	logic [REM_W+1:0] rem2;
	logic [REM_W+1:0] trial;
	logic             ge;
	sq_t              nxt;

	always_comb begin
		rem2  = {d.rem, d.rad[RAD_W-1 -: 2]};
		trial = {2'b00, d.root, 2'b01};
		ge    = rem2 >= trial;
		nxt   = d;
		nxt.rem  = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
		nxt.root = {d.root[ROOT_W-2:0], ge};
		nxt.rad  = {d.rad[RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of restoring division, for both root lanes.
// ----------------------------------------------------------------------------
module qrs_div_cell import qrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  dv_t  d,
	output dv_t  q
);

	dv_t nxt;
	logic [1:0] ge;

	always_comb begin
		nxt = d;
		for (int i = 0; i < 2; i++) begin
			ge[i] = d.lane[i].rem >= d.lane[i].dsh;
			nxt.lane[i].rem = ge[i] ? d.lane[i].rem - d.lane[i].dsh : d.lane[i].rem;
			nxt.lane[i].quo = {d.lane[i].quo[QUO_W-2:0], ge[i]};
			nxt.lane[i].dsh = d.lane[i].dsh >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== hw/rtl/quadratic_root_solver_top.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Classifies c*x^2 + b*x + a and returns its real roots in signed fixed point.
// ----------------------------------------------------------------------------
// The solver takes one equation per cycle unless the output buffer is full, and
// returns one solution per equation, in order. From accept to result an equation
// passes three front stages (operand magnitudes, the two 32x32 products, the
// discriminant), a chain of 34 square-root cells, three stages that form the
// numerators and the divider overflow check, and a chain of 33 divider cells;
// the last stage clips, orders the roots and writes a two-entry output buffer.
// The pipeline holds only while that buffer is full.
module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic eq_valid,
	output logic eq_stall,
	input  eq_t  eq_data,
	output logic sol_valid,
	input  logic sol_stall,
	output sol_t sol_data
);

	logic       en;
	logic [1:0] cnt_q;
	sol_t       head_q, tail_q;

	assign en       = (cnt_q != 2'd2);
	assign eq_stall = !en;

	// ---- stage 1: capture and magnitudes
	logic               v_s1, hi_s1, acneg_s1;
	logic signed [31:0] a_s1, b_s1, c_s1;
	logic [31:0]        ma_s1, mb_s1, mc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= eq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= eq_data.coef_constant;
			b_s1     <= eq_data.coef_linear;
			c_s1     <= eq_data.coef_square;
			hi_s1    <= eq_data.higher_terms_present;
			ma_s1    <= eq_data.coef_constant[31] ? 32'(-eq_data.coef_constant)
				: 32'(eq_data.coef_constant);
			mb_s1    <= eq_data.coef_linear[31] ? 32'(-eq_data.coef_linear)
				: 32'(eq_data.coef_linear);
			mc_s1    <= eq_data.coef_square[31] ? 32'(-eq_data.coef_square)
				: 32'(eq_data.coef_square);
			acneg_s1 <= eq_data.coef_constant[31] ^ eq_data.coef_square[31];
		end
	end

	// ---- stage 2: products
	logic               v_s2, hi_s2, acneg_s2;
	logic signed [31:0] a_s2, b_s2, c_s2;
	logic [63:0]        bb_s2, p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			hi_s2    <= hi_s1;
			acneg_s2 <= acneg_s1;
			bb_s2    <= 64'(mb_s1) * 64'(mb_s1);
			p_s2     <= 64'(ma_s1) * 64'(mc_s1);
		end
	end

	// ---- stage 3: discriminant and classification
	logic [DISC_W-1:0] p4, bbx, disc;
	logic [2:0]        kind3;
	sq_t               sq [SQ_STEPS+1];

	always_comb begin
		p4   = {p_s2, 2'b00} & {DISC_W{1'b1}};
		bbx  = DISC_W'(bb_s2);
		disc = '0;
		if (hi_s2) begin
			kind3 = OUT_HIGH;
		end else if (c_s2 != 32'sd0) begin
			if (acneg_s2 || p_s2 == 64'd0) begin
				disc  = bbx + p4;
				kind3 = (disc != '0) ? OUT_TWO : OUT_DOUBLE;
			end else if (p4 > bbx) begin
				kind3 = OUT_COMPLEX;
			end else begin
				disc  = bbx - p4;
				kind3 = (disc != '0) ? OUT_TWO : OUT_DOUBLE;
			end
		end else if (b_s2 != 32'sd0) begin
			kind3 = OUT_LINEAR;
		end else begin
			kind3 = (a_s2 == 32'sd0) ? OUT_ALL : OUT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq[0] <= '0;
		end else if (en) begin
			sq[0].valid     <= v_s2;
			sq[0].meta.kind <= kind3;
			sq[0].meta.a    <= a_s2;
			sq[0].meta.b    <= b_s2;
			sq[0].meta.c    <= c_s2;
			sq[0].rem       <= '0;
			sq[0].root      <= '0;
			sq[0].rad       <= RAD_W'(disc);
		end
	end

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (sq[g]),
			.q      (sq[g+1])
		);
	end

	// ---- prep A: numerators, denominator, magnitudes
	sq_t                sqo;
	logic signed [35:0] nb, s36;
	logic signed [35:0] num [2];
	logic signed [33:0] den;
	logic               va_q;
	logic [2:0]         kind_a_q;
	logic [34:0]        n_a_q [2];
	logic [32:0]        d_a_q;
	logic [1:0]         neg_a_q;

	always_comb begin
		sqo = sq[SQ_STEPS];
		nb  = -36'(sqo.meta.b);
		s36 = 36'(sqo.root);
		if (sqo.meta.kind == OUT_LINEAR) begin
			num[0] = -36'(sqo.meta.a);
			num[1] = num[0];
			den    = 34'(sqo.meta.b);
		end else if (sqo.meta.kind == OUT_TWO) begin
			num[0] = nb - s36;
			num[1] = nb + s36;
			den    = 34'(sqo.meta.c) <<< 1;
		end else begin
			num[0] = nb;
			num[1] = nb;
			den    = 34'(sqo.meta.c) <<< 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
		end else if (en) begin
			va_q <= sqo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_a_q <= sqo.meta.kind;
			d_a_q    <= den[33] ? 33'(-den) : 33'(den);
			for (int i = 0; i < 2; i++) begin
				n_a_q[i]   <= num[i][35] ? 35'(-num[i]) : 35'(num[i]);
				neg_a_q[i] <= num[i][35] ^ den[33];
			end
		end
	end

	// ---- prep B: rounded dividend and doubled divisor
	logic             vb_q;
	logic [2:0]       kind_b_q;
	logic [DIV_W-1:0] n_b_q [2];
	logic [DIV_W-1:0] d2_b_q;
	logic [1:0]       neg_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= 1'b0;
		end else if (en) begin
			vb_q <= va_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_b_q <= kind_a_q;
			d2_b_q   <= DIV_W'(d_a_q) << 1;
			neg_b_q  <= neg_a_q;
			for (int i = 0; i < 2; i++) begin
				n_b_q[i] <= (DIV_W'(n_a_q[i]) << (FRACTION_BITS + 1)) + DIV_W'(d_a_q);
			end
		end
	end

	// ---- prep C: overflow check, load the divider chain
	dv_t dv [QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= '0;
		end else if (en) begin
			dv[0].valid <= vb_q;
			dv[0].kind  <= kind_b_q;
			for (int i = 0; i < 2; i++) begin
				dv[0].lane[i].rem <= n_b_q[i];
				dv[0].lane[i].dsh <= d2_b_q << (QUO_W - 1);
				dv[0].lane[i].quo <= '0;
				dv[0].lane[i].neg <= neg_b_q[i];
				dv[0].lane[i].ovf <= n_b_q[i] >= (d2_b_q << QUO_W);
			end
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		qrs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (dv[g]),
			.q      (dv[g+1])
		);
	end

	// ---- final: sign, clip, order
	dv_t                dvo;
	logic signed [31:0] rv [2];
	logic [1:0]         sat;
	logic               has_root;
	sol_t               res;
	logic               push, pop;

	always_comb begin
		dvo = dv[QUO_W];
		for (int i = 0; i < 2; i++) begin
			sat[i] = dvo.lane[i].ovf
				|| (!dvo.lane[i].neg && dvo.lane[i].quo > 33'h0_7FFF_FFFF)
				|| (dvo.lane[i].neg && dvo.lane[i].quo > 33'h0_8000_0000);
			if (sat[i]) begin
				rv[i] = dvo.lane[i].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				rv[i] = dvo.lane[i].neg ? -$signed(dvo.lane[i].quo[31:0])
					: $signed(dvo.lane[i].quo[31:0]);
			end
		end
		has_root = (dvo.kind == OUT_LINEAR) || (dvo.kind == OUT_TWO)
			|| (dvo.kind == OUT_DOUBLE);
		res.outcome = dvo.kind;
		if (!has_root) begin
			res.root_low  = '0;
			res.root_high = '0;
			res.saturated = 1'b0;
		end else begin
			res.root_low  = (rv[0] < rv[1]) ? rv[0] : rv[1];
			res.root_high = (rv[0] < rv[1]) ? rv[1] : rv[0];
			res.saturated = |sat;
		end
	end

	// ---- two-entry output buffer
	assign push      = en && dvo.valid;
	assign pop       = sol_valid && !sol_stall;
	assign sol_valid = (cnt_q != 2'd0);
	assign sol_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= res;
			end
			if (push && cnt_q == 2'd2) begin
				tail_q <= res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= res;
			end else begin
				tail_q <= res;
			end
		end
	end

endmodule

// ===== sim/tb_quadratic_root_solver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_top
// Self-checking bench for the quadratic root solver: a table of directed
// equations, then random ones, each solution checked against a predictor.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	localparam int FB        = 16;
	localparam int LATENCY   = 74;
	localparam int N_RANDOM  = 500;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		eq_t  eq;
		logic has_sol;
		sol_t sol;
	} row_t;

	logic clk;
	logic arst_n;
	logic eq_valid;
	logic eq_stall;
	eq_t  eq_data;
	logic sol_valid;
	logic sol_stall;
	sol_t sol_data;

	sol_t   sol_queue[$];
	int     mismatch_count;
	longint cycle_count;
	int     send_idle_pct;
	int     recv_idle_pct;
	row_t   rows[$];

	quadratic_root_solver_top #(.FRACTION_BITS(FB)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.eq_valid (eq_valid),
		.eq_stall (eq_stall),
		.eq_data  (eq_data),
		.sol_valid(sol_valid),
		.sol_stall(sol_stall),
		.sol_data (sol_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rounded fixed-point quotient num * 2^FB / den, ties away from zero.
	function automatic logic signed [127:0] fx_div(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		n = n << FB;
		q = (2 * n + d) / (2 * d);
		return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [31:0] clip(logic signed [127:0] v, ref logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// The discriminant stays below 2^67, so its root fits in 34 bits.
	function automatic logic [127:0] floor_sqrt(logic [127:0] v);
		logic [127:0] r;
		logic [127:0] bitv;
		r = 0;
		for (int k = 35; k >= 0; k--) begin
			bitv = r | (128'd1 << k);
			if (bitv * bitv <= v) r = bitv;
		end
		return r;
	endfunction

	function automatic sol_t solve_equation(eq_t e);
		sol_t s;
		logic signed [127:0] a, b, c, disc, sq, x1, x2;
		logic sat;
		s = '0;
		sat = 1'b0;
		a = e.coef_constant;
		b = e.coef_linear;
		c = e.coef_square;
		if (e.higher_terms_present) begin
			s.outcome = OUT_HIGH;
		end else if (c != 0) begin
			disc = b * b - 4 * a * c;
			if (disc < 0) begin
				s.outcome = OUT_COMPLEX;
			end else if (disc == 0) begin
				s.outcome = OUT_DOUBLE;
				s.root_low = clip(fx_div(-b, 2 * c), sat);
				s.root_high = s.root_low;
			end else begin
				s.outcome = OUT_TWO;
				sq = floor_sqrt(disc);
				x1 = clip(fx_div(-b - sq, 2 * c), sat);
				x2 = clip(fx_div(-b + sq, 2 * c), sat);
				s.root_low = (x1 < x2) ? x1[31:0] : x2[31:0];
				s.root_high = (x1 < x2) ? x2[31:0] : x1[31:0];
			end
		end else if (b != 0) begin
			s.outcome = OUT_LINEAR;
			s.root_low = clip(fx_div(-a, b), sat);
			s.root_high = s.root_low;
		end else begin
			s.outcome = (a == 0) ? OUT_ALL : OUT_NONE;
		end
		s.saturated = sat;
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 8) - 4;
			1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			2: return {{16{1'b0}}, 16'h0} + ($signed($urandom_range(0, 40)) - 20) * 32'sh10000;
			default: return $urandom;
		endcase
	endfunction

	// Build an equation with chosen integer roots, or random noise.
	function automatic eq_t rand_equation();
		eq_t e;
		logic signed [31:0] r1, r2, k;
		e = '0;
		e.higher_terms_present = ($urandom_range(0, 15) == 0);
		case ($urandom_range(0, 3))
			0: begin
				r1 = $signed($urandom_range(0, 40)) - 20;
				r2 = ($urandom_range(0, 2) == 0) ? r1 : $signed($urandom_range(0, 40)) - 20;
				k = $signed($urandom_range(1, 64)) * (($urandom_range(0, 1)) ? 1 : -1);
				e.coef_square = k <<< 10;
				e.coef_linear = -(r1 + r2) * (k <<< 10);
				e.coef_constant = r1 * r2 * (k <<< 10);
			end
			1: begin
				e.coef_constant = rand_coef();
				e.coef_linear = ($urandom_range(0, 1)) ? rand_coef() : 32'sd0;
				e.coef_square = 32'sd0;
			end
			default: begin
				e.coef_constant = rand_coef();
				e.coef_linear = rand_coef();
				e.coef_square = rand_coef();
			end
		endcase
		return e;
	endfunction

	function automatic eq_t mk(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic h);
		eq_t e;
		e.coef_constant = a;
		e.coef_linear = b;
		e.coef_square = c;
		e.higher_terms_present = h;
		return e;
	endfunction

	task automatic add_row(eq_t e);
		row_t r;
		r.eq = e;
		r.has_sol = 1'b0;
		r.sol = '0;
		rows.insert(rows.size(), r);
	endtask

	task automatic add_known(eq_t e, logic [2:0] oc);
		row_t r;
		r.eq = e;
		r.has_sol = 1'b1;
		r.sol = '0;
		r.sol.outcome = oc;
		rows.insert(rows.size(), r);
	endtask

	task automatic send_equation(eq_t e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			eq_valid <= 1'b0;
			@(posedge clk);
		end
		eq_valid <= 1'b1;
		eq_data <= e;
		sol_queue.insert(sol_queue.size(), solve_equation(e));
		@(posedge clk);
		while (eq_stall) @(posedge clk);
	endtask

	task automatic send_row(row_t r);
		sol_t p;
		p = solve_equation(r.eq);
		if (r.has_sol && p != r.sol)
			report_mismatch("table row outcome", 32'(p.outcome), 32'(r.sol.outcome));
		send_equation(r.eq);
	endtask

	// Receiver side: random stall, check each accepted transaction.
	always @(posedge clk) begin
		sol_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (sol_valid && !sol_stall) begin
				if (sol_queue.size() == 0) begin
					report_mismatch("unexpected outcome", 32'(sol_data.outcome), 32'd0);
				end else begin
					want = sol_queue.pop_front();
					if (sol_data.outcome != want.outcome)
						report_mismatch("outcome", sol_data.outcome, want.outcome);
					if (sol_data.root_low != want.root_low)
						report_mismatch("root_low", sol_data.root_low, want.root_low);
					if (sol_data.root_high != want.root_high)
						report_mismatch("root_high", sol_data.root_high, want.root_high);
					if (sol_data.saturated != want.saturated)
						report_mismatch("saturated", sol_data.saturated, want.saturated);
				end
			end
			sol_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[quadratic_root_solver_top] ERROR");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		mismatch_count = 0;
		arst_n = 1'b0;
		eq_valid = 1'b0;
		eq_data = '0;
		sol_stall = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 56;

		add_known(mk(0, 0, 0, 1'b0), OUT_ALL);
		add_known(mk(32'sh10000, 0, 0, 1'b0), OUT_NONE);
		add_known(mk(32'sh80000000, 0, 0, 1'b0), OUT_NONE);
		add_known(mk(0, 0, 0, 1'b1), OUT_HIGH);
		add_known(mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1), OUT_HIGH);
		add_known(mk(32'sh10000, 0, 32'sh10000, 1'b0), OUT_COMPLEX);
		add_row(mk(32'sh20000, 32'sh10000, 0, 1'b0));
		add_row(mk(32'sh7fffffff, 1, 0, 1'b0));
		add_row(mk(32'sh80000000, 1, 0, 1'b0));
		add_row(mk(32'sh80000000, 32'sh80000000, 0, 1'b0));
		add_row(mk(32'sh10000, 32'sh20000, 32'sh10000, 1'b0));
		add_row(mk(0, 32'sh7fffffff, 1, 1'b0));
		add_row(mk(0, 32'sh80000000, 32'sh80000000, 1'b0));
		add_row(mk(-32'sh60000, 32'sh10000, 32'sh10000, 1'b0));
		add_row(mk(0, 1, 1, 1'b0));
		add_row(mk(0, 0, 32'sh10000, 1'b0));
		add_row(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
		add_row(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0));
		add_row(mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
		add_row(mk(32'sh7fffffff, 0, 32'sh80000000, 1'b0));
		add_row(mk(32'shffffffff, 32'shffffffff, 32'shffffffff, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_row(rows[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 56;
				recv_idle_pct = 11;
			end
			if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_equation(rand_equation());
		end
		eq_valid <= 1'b0;

		while (sol_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("[quadratic_root_solver_top] OK");
		else
			$display("[quadratic_root_solver_top] ERROR");
		$finish;
	end

endmodule
